// File: hdl/gjd_pkg.sv
package gjd_pkg;

  // Operation codes carried on the request's tuser
  typedef enum logic [1:0] {
    OP_DATE_TO_DAY = 2'd0,
    OP_DAY_TO_DATE = 2'd1,
    OP_ADD_DAYS    = 2'd2,
    OP_DISTANCE    = 2'd3
  } op_t;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DV_W    = 24;
  localparam int JD_W    = 23;

  // Register stages of the two datapath units
  localparam int D2J_STAGES = 3;
  localparam int J2D_STAGES = 11;

  typedef logic [D2J_STAGES-1:0] d2j_en_t;
  typedef logic [J2D_STAGES-1:0] j2d_en_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Days before the month in a March-based year: (153*mm + 2) / 5,
  // with January and February (and month 0) counted as months 11, 12, 10
  // of the previous year.
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mon);
    logic [8:0] f;
    case (mon)
      4'd0:    f = 9'd275;
      4'd1:    f = 9'd306;
      4'd2:    f = 9'd337;
      4'd3:    f = 9'd0;
      4'd4:    f = 9'd31;
      4'd5:    f = 9'd61;
      4'd6:    f = 9'd92;
      4'd7:    f = 9'd122;
      4'd8:    f = 9'd153;
      4'd9:    f = 9'd184;
      4'd10:   f = 9'd214;
      4'd11:   f = 9'd245;
      4'd12:   f = 9'd275;
      4'd13:   f = 9'd306;
      4'd14:   f = 9'd337;
      default: f = 9'd367;
    endcase
    return f;
  endfunction

endpackage

// File: hdl/gjd_date2day.sv
// Gregorian date to Julian day number, three register stages.
module gjd_date2day (
  input  logic                      clk,
  input  gjd_pkg::d2j_en_t          en,
  input  gjd_pkg::date_t            date,
  output logic [gjd_pkg::JD_W-1:0]  jd
);
  import gjd_pkg::*;

  // yy / 100 by reciprocal; exact since yy < 2^15 and 100 < 2^7
  localparam int          K100 = 22;
  localparam logic [15:0] M100 = 16'((longint'(1) << K100) / 100 + 1);

  logic        early;
  logic [14:0] yy_next;
  logic [9:0]  dsum_next;

  logic [14:0] yy1;
  logic [9:0]  dsum1;

  logic [22:0] p365;
  logic [30:0] p100;
  logic [12:0] q4;
  logic [9:0]  dsum2;

  logic [8:0]  q100;
  logic [6:0]  q400;
  logic [24:0] jd_sum;

  // stage 1: shifted year and day-of-year part
  always_comb begin
    early     = date.month <= 4'd2;
    yy_next   = 15'(date.year) + 15'd4800 - 15'(early);
    dsum_next = 10'(date.day) + 10'(month_offset(date.month));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      yy1   <= yy_next;
      dsum1 <= dsum_next;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p365  <= 23'(32'(yy1) * 32'd365);
      p100  <= 31'(31'(yy1) * 31'(M100));
      q4    <= yy1[14:2];
      dsum2 <= dsum1;
    end
  end

  // stage 3: leap corrections and final sum (always positive, < 2^23)
  always_comb begin
    q100   = p100[30:22];
    q400   = q100[8:2];
    jd_sum = 25'(p365) + 25'(q4) - 25'(q100) + 25'(q400) + 25'(dsum2) - 25'd32045;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      jd <= jd_sum[JD_W-1:0];
    end
  end

endmodule

// File: hdl/gjd_day2date.sv
// Shifted day number (jd + 32044) to Gregorian date, eleven register
// stages. Every division truncates toward zero: sign and magnitude are
// split, the magnitude goes through a reciprocal multiply, sign restored.
module gjd_day2date (
  input  logic                 clk,
  input  gjd_pkg::j2d_en_t     en,
  input  logic signed [24:0]   a_val,
  output logic signed [16:0]   year,
  output logic signed [5:0]    month,
  output logic signed [10:0]   day
);
  import gjd_pkg::*;

  // Reciprocals: exact when dividend < 2^K / divisor bound
  localparam int          K1 = 44;
  localparam logic [26:0] M1 = 27'((longint'(1) << K1) / 146097 + 1);
  localparam int          K2 = 29;
  localparam logic [18:0] M2 = 19'((longint'(1) << K2) / 1461 + 1);
  localparam int          K3 = 19;
  localparam logic [11:0] M3 = 12'((longint'(1) << K3) / 153 + 1);
  localparam int          K5 = 14;
  localparam logic [11:0] M5 = 12'((longint'(1) << K5) / 5 + 1);

  // stage 1
  logic signed [26:0] n4;
  logic signed [26:0] n4_abs;
  logic [25:0]        s1_mag;
  logic               s1_neg;
  logic signed [24:0] s1_a;
  // stage 2
  logic [52:0]        s2_prod;
  logic               s2_neg;
  logic signed [24:0] s2_a;
  // stage 3
  logic [8:0]         bmag;
  logic [26:0]        s3_p;
  logic [8:0]         s3_bmag;
  logic               s3_neg;
  logic signed [24:0] s3_a;
  // stage 4
  logic [24:0]        p4;
  logic signed [26:0] c_full;
  logic signed [16:0] c;
  logic signed [18:0] nc;
  logic signed [18:0] nc_abs;
  logic [15:0]        b100;
  logic signed [16:0] yb;
  logic [17:0]        s4_magc;
  logic               s4_sc;
  logic signed [16:0] s4_c;
  logic signed [16:0] s4_ybase;
  // stage 5
  logic [36:0]        s5_prod;
  logic               s5_sc;
  logic signed [16:0] s5_c;
  logic signed [16:0] s5_ybase;
  // stage 6
  logic [7:0]         e4mag;
  logic [18:0]        s6_q;
  logic [7:0]         s6_e4mag;
  logic               s6_sc;
  logic signed [16:0] s6_c;
  logic signed [16:0] s6_ybase;
  // stage 7
  logic [16:0]        q4v;
  logic signed [17:0] e_full;
  logic signed [9:0]  e;
  logic signed [11:0] e_ext;
  logic signed [11:0] n5;
  logic signed [11:0] n5_abs;
  logic signed [16:0] e4s;
  logic [10:0]        s7_mag5;
  logic               s7_se;
  logic signed [9:0]  s7_e;
  logic signed [16:0] s7_ye;
  // stage 8
  logic [22:0]        s8_prod;
  logic               s8_se;
  logic signed [9:0]  s8_e;
  logic signed [16:0] s8_ye;
  // stage 9
  logic [3:0]         kmag;
  logic               kneg;
  logic [10:0]        k153;
  logic [10:0]        t;
  logic signed [5:0]  ks;
  logic signed [5:0]  qs;
  logic signed [5:0]  m_next;
  logic signed [16:0] y_next;
  logic [10:0]        s9_t;
  logic               s9_kneg;
  logic signed [9:0]  s9_e;
  logic signed [5:0]  s9_m;
  logic signed [16:0] s9_y;
  // stage 10
  logic [22:0]        s10_prod;
  logic               s10_kneg;
  logic signed [9:0]  s10_e;
  logic signed [5:0]  s10_m;
  logic signed [16:0] s10_y;
  // stage 11
  logic [8:0]         g;
  logic signed [10:0] d_next;

  // stage 1: |4a + 3|
  always_comb begin
    n4     = {a_val, 2'b11};
    n4_abs = a_val[24] ? -n4 : n4;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mag <= n4_abs[25:0];
      s1_neg <= a_val[24];
      s1_a   <= a_val;
    end
  end

  // stage 2: |b| = |4a + 3| / 146097
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_prod <= 53'(s1_mag) * 53'(M1);
      s2_neg  <= s1_neg;
      s2_a    <= s1_a;
    end
  end

  // stage 3: 146097 * |b|
  assign bmag = s2_prod[52:44];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_p    <= 27'(bmag) * 27'd146097;
      s3_bmag <= bmag;
      s3_neg  <= s2_neg;
      s3_a    <= s2_a;
    end
  end

  // stage 4: c = a - trunc(146097 b / 4), then |4c + 3|; century part of year
  always_comb begin
    p4     = s3_p[26:2];
    c_full = s3_neg ? ($signed({{2{s3_a[24]}}, s3_a}) + $signed({2'b00, p4}))
                    : ($signed({{2{s3_a[24]}}, s3_a}) - $signed({2'b00, p4}));
    c      = c_full[16:0];
    nc     = {c, 2'b11};
    nc_abs = c[16] ? -nc : nc;
    b100   = 16'(s3_bmag) * 16'd100;
    yb     = s3_neg ? -$signed({1'b0, b100}) : $signed({1'b0, b100});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_magc  <= nc_abs[17:0];
      s4_sc    <= c[16];
      s4_c     <= c;
      s4_ybase <= yb - 17'sd4800;
    end
  end

  // stage 5: |e4| = |4c + 3| / 1461
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_prod  <= 37'(s4_magc) * 37'(M2);
      s5_sc    <= s4_sc;
      s5_c     <= s4_c;
      s5_ybase <= s4_ybase;
    end
  end

  // stage 6: 1461 * |e4|
  assign e4mag = s5_prod[36:29];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_q     <= 19'(e4mag) * 19'd1461;
      s6_e4mag <= e4mag;
      s6_sc    <= s5_sc;
      s6_c     <= s5_c;
      s6_ybase <= s5_ybase;
    end
  end

  // stage 7: e = c - trunc(1461 e4 / 4), then |5e + 2|
  always_comb begin
    q4v    = s6_q[18:2];
    e_full = s6_sc ? ($signed({s6_c[16], s6_c}) + $signed({1'b0, q4v}))
                   : ($signed({s6_c[16], s6_c}) - $signed({1'b0, q4v}));
    e      = e_full[9:0];
    e_ext  = {{2{e[9]}}, e};
    n5     = (e_ext <<< 2) + e_ext + 12'sd2;
    n5_abs = e[9] ? -n5 : n5;
    e4s    = s6_sc ? -$signed({9'b0, s6_e4mag}) : $signed({9'b0, s6_e4mag});
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_mag5 <= n5_abs[10:0];
      s7_se   <= e[9];
      s7_e    <= e;
      s7_ye   <= s6_ybase + e4s;
    end
  end

  // stage 8: |k| = |5e + 2| / 153
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_prod <= 23'(s7_mag5) * 23'(M3);
      s8_se   <= s7_se;
      s8_e    <= s7_e;
      s8_ye   <= s7_ye;
    end
  end

  // stage 9: month, year, and |153k + 2| for the day correction
  always_comb begin
    kmag   = s8_prod[22:19];
    kneg   = s8_se && (kmag != 4'd0);
    k153   = 11'(kmag) * 11'd153;
    t      = kneg ? (k153 - 11'd2) : (k153 + 11'd2);
    ks     = kneg ? -$signed({2'b00, kmag}) : $signed({2'b00, kmag});
    qs     = (kmag >= 4'd10) ? (kneg ? -6'sd1 : 6'sd1) : 6'sd0;
    m_next = ks + 6'sd3 - ((qs <<< 3) + (qs <<< 2));
    y_next = s8_ye + {{11{qs[5]}}, qs};
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_t    <= t;
      s9_kneg <= kneg;
      s9_e    <= s8_e;
      s9_m    <= m_next;
      s9_y    <= y_next;
    end
  end

  // stage 10: |153k + 2| / 5
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_prod <= 23'(s9_t) * 23'(M5);
      s10_kneg <= s9_kneg;
      s10_e    <= s9_e;
      s10_m    <= s9_m;
      s10_y    <= s9_y;
    end
  end

  // stage 11: day of month
  always_comb begin
    g      = s10_prod[22:14];
    d_next = s10_kneg ? ($signed({s10_e[9], s10_e}) + $signed({2'b00, g}) + 11'sd1)
                      : ($signed({s10_e[9], s10_e}) - $signed({2'b00, g}) + 11'sd1);
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      day   <= d_next;
      month <= s10_m;
      year  <= s10_y;
    end
  end

endmodule

// File: hdl/gregorian_julian_day_converter_core.sv
// Gregorian calendar / Julian day number converter.
//
// Request channel (s_*): s_tuser is the operation (date to day number,
// day number to date, date plus signed offset, distance between dates);
// s_tdata carries both dates and the signed 24-bit day value.
// Result channel (m_*): m_tdata carries the day number or distance and the
// resulting date; m_tuser flags a resulting year outside 0..9999. Fields
// that an operation does not produce read as zero.
//
// From request acceptance to m_tvalid, three stages turn each date into
// a day number (both dates in parallel), one stage forms the offset sum
// and the distance, eleven stages turn a day number back into a date, and
// one output register formats the result. Throughput is one request per
// cycle unless backpressure stalls the pipeline; every division by 100,
// 146097, 1461, 153 or 5 is a reciprocal multiply followed by a register.
//
// Reset clears all stage valid bits; data registers are not reset.
// When the receiver holds m_tready low the result holds, and the stages
// behind it keep filling empty slots; s_tready drops only once every stage
// holds a request. Nothing is dropped or repeated under backpressure.
module gregorian_julian_day_converter_core (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        s_tvalid,
  output logic        s_tready,
  // year_a[13:0] month_a[17:14] day_a[22:18] year_b[36:23] month_b[40:37]
  // day_b[45:41] day_value[69:46] zero[71:70]
  input  logic [71:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  // day_result[22:0] year_out[36:23] month_out[40:37] day_out[45:41] zero[47:46]
  output logic [47:0] m_tdata,
  // out_of_range[0]
  output logic        m_tuser
);
  import gjd_pkg::*;

  localparam int S4_IDX  = D2J_STAGES;            // offset/distance stage
  localparam int J2D_LO  = D2J_STAGES + 1;        // first day-to-date stage
  localparam int NSTG    = D2J_STAGES + 1 + J2D_STAGES + 1;
  localparam int OUT_IDX = NSTG - 1;

  // Stage control: a stage loads whenever it or any stage downstream of it
  // is empty, or m_tready is high.
  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] en;

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      en[i] = m_tready || ((valid >> i) != ({NSTG{1'b1}} >> i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= s_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[OUT_IDX];

  // Request unpacking
  date_t             date_a;
  date_t             date_b;
  op_t               op_in;
  logic signed [23:0] dv_in;

  always_comb begin
    date_a = '{year: s_tdata[13:0], month: s_tdata[17:14], day: s_tdata[22:18]};
    date_b = '{year: s_tdata[36:23], month: s_tdata[40:37], day: s_tdata[45:41]};
    dv_in  = s_tdata[69:46];
    op_in  = op_t'(s_tuser);
  end

  // Date to day number, both dates side by side
  logic [JD_W-1:0] jd_a;
  logic [JD_W-1:0] jd_b;

  gjd_date2day u_d2j_a (
    .clk  (clk),
    .en   (en[D2J_STAGES-1:0]),
    .date (date_a),
    .jd   (jd_a)
  );

  gjd_date2day u_d2j_b (
    .clk  (clk),
    .en   (en[D2J_STAGES-1:0]),
    .date (date_b),
    .jd   (jd_b)
  );

  // Operation and offset travel alongside the first unit
  op_t                op_d [D2J_STAGES];
  logic signed [23:0] dv_d [D2J_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op_d[0] <= op_in;
      dv_d[0] <= dv_in;
    end
    for (int i = 1; i < D2J_STAGES; i++) begin
      if (en[i]) begin
        op_d[i] <= op_d[i-1];
        dv_d[i] <= dv_d[i-1];
      end
    end
  end

  // Offset sum (shifted by 32044 for the date unit) and distance
  op_t                op_s;
  logic [JD_W-1:0]    base;
  logic signed [24:0] a_next;
  logic [23:0]        diff_fwd;
  logic [23:0]        diff_rev;
  logic [JD_W-1:0]    dres_next;
  logic signed [24:0] a_val;
  op_t                op4;
  logic [JD_W-1:0]    dres4;

  always_comb begin
    op_s      = op_d[D2J_STAGES-1];
    base      = (op_s == OP_DAY_TO_DATE) ? '0 : jd_a;
    a_next    = $signed({2'b00, base}) + $signed({dv_d[D2J_STAGES-1][23],
                dv_d[D2J_STAGES-1]}) + 25'sd32044;
    diff_fwd  = {1'b0, jd_a} - {1'b0, jd_b};
    diff_rev  = {1'b0, jd_b} - {1'b0, jd_a};
    dres_next = (op_s == OP_DATE_TO_DAY) ? jd_a
              : (diff_fwd[23] ? diff_rev[JD_W-1:0] : diff_fwd[JD_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en[S4_IDX]) begin
      a_val <= a_next;
      op4   <= op_s;
      dres4 <= dres_next;
    end
  end

  // Day number to date
  logic signed [16:0] year_s;
  logic signed [5:0]  month_s;
  logic signed [10:0] day_s;

  gjd_day2date u_j2d (
    .clk   (clk),
    .en    (en[OUT_IDX-1:J2D_LO]),
    .a_val (a_val),
    .year  (year_s),
    .month (month_s),
    .day   (day_s)
  );

  op_t             op_q   [J2D_STAGES];
  logic [JD_W-1:0] dres_q [J2D_STAGES];

  always_ff @(posedge clk) begin
    if (en[J2D_LO]) begin
      op_q[0]   <= op4;
      dres_q[0] <= dres4;
    end
    for (int i = 1; i < J2D_STAGES; i++) begin
      if (en[J2D_LO+i]) begin
        op_q[i]   <= op_q[i-1];
        dres_q[i] <= dres_q[i-1];
      end
    end
  end

  // Output register
  logic               date_op;
  logic               oor_next;
  logic [JD_W-1:0]    day_result;
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;
  logic               out_of_range;

  always_comb begin
    date_op  = (op_q[J2D_STAGES-1] == OP_DAY_TO_DATE) ||
               (op_q[J2D_STAGES-1] == OP_ADD_DAYS);
    oor_next = date_op && ((year_s < 17'sd0) || (year_s > 17'sd9999));
  end

  always_ff @(posedge clk) begin
    if (en[OUT_IDX]) begin
      day_result   <= date_op ? '0 : dres_q[J2D_STAGES-1];
      year_out     <= date_op ? year_s[YEAR_W-1:0] : '0;
      month_out    <= date_op ? month_s[MONTH_W-1:0] : '0;
      day_out      <= date_op ? day_s[DAY_W-1:0] : '0;
      out_of_range <= oor_next;
    end
  end

  assign m_tdata = {2'b00, day_out, month_out, year_out, day_result};
  assign m_tuser = out_of_range;

`ifndef SYNTHESIS
  // An empty output register means every stage can advance
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled while output register empty");

  // Backpressure at the input only when the whole pipeline is full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> ((&valid) && !m_tready))
    else $error("request stalled with a free stage");

  // Range flag only on date results, which carry no day number
  a_oor_no_day_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (day_result == '0))
    else $error("range flag set on a day-number result");

  // An in-range date result has a month no greater than 12 and a nonzero day
  a_in_range_date_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && (month_out != '0)) |->
      ((month_out <= 4'd12) && (day_out != '0)))
    else $error("in-range date with bad month or day");
`endif

endmodule

// File: tb/gregorian_julian_day_converter_core_tb.sv
`timescale 1ns / 100ps

module gregorian_julian_day_converter_core_tb;
  import gjd_pkg::*;

  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_LIMIT     = 1000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES    = 40;    // idle cycles after the last awaited result
  localparam int PRINT_CAP       = 30;

  // Valid year range 0000-01-01 .. 9999-12-31 as day numbers
  localparam int JD_FIRST = 1721060;
  localparam int JD_LAST  = 5373484;

  typedef struct packed {
    logic [JD_W-1:0]    day_result;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               out_of_range;
  } conv_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  conv_result_t awaited_results[$];
  int           mismatch_count;
  int           op_count[4];
  int           range_flag_count;
  bit           src_no_gap;
  bit           sink_no_stall;

  gregorian_julian_day_converter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic. longint keeps every intermediate signed, so division
  // truncates toward zero exactly like the block's formulas; stray month and
  // day codes flow through unchecked.
  // ---------------------------------------------------------------------------
  function automatic longint day_number_of(input date_t dt);
    longint yr, mon, dd, a, yy, mm;
    yr  = dt.year;
    mon = dt.month;
    dd  = dt.day;
    a   = (14 - mon) / 12;
    yy  = yr + 4800 - a;
    mm  = mon + 12 * a - 3;
    return dd + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
  endfunction

  function automatic void calendar_of(input longint jd, output longint y, output longint m,
                                      output longint d);
    longint a, b, c, e4, e, k;
    a  = jd + 32044;
    b  = (4 * a + 3) / 146097;
    c  = a - (146097 * b) / 4;
    e4 = (4 * c + 3) / 1461;
    e  = c - (1461 * e4) / 4;
    k  = (5 * e + 2) / 153;
    d  = e - (153 * k + 2) / 5 + 1;
    m  = k + 3 - 12 * (k / 10);
    y  = 100 * b + e4 - 4800 + k / 10;
  endfunction

  // Expected result of one request; fields an operation does not produce stay 0
  function automatic conv_result_t convert_request(input op_t op, input date_t a, input date_t b,
                                                   input logic signed [DV_W-1:0] dv);
    conv_result_t r;
    longint offs, y, m, d, delta;
    bit dated;
    r     = '0;
    offs  = dv;
    dated = 1'b0;
    y = 0; m = 0; d = 0;
    case (op)
      OP_DATE_TO_DAY: r.day_result = JD_W'(day_number_of(a));
      OP_DAY_TO_DATE: begin
        calendar_of(offs, y, m, d);
        dated = 1'b1;
      end
      OP_ADD_DAYS: begin
        calendar_of(day_number_of(a) + offs, y, m, d);
        dated = 1'b1;
      end
      default: begin
        delta = day_number_of(a) - day_number_of(b);
        r.day_result = JD_W'((delta < 0) ? -delta : delta);
      end
    endcase
    if (dated) begin
      r.year         = YEAR_W'(y);  // wraps to field width
      r.month        = MONTH_W'(m);
      r.day          = DAY_W'(d);
      r.out_of_range = (y < 0) || (y > 9999);
    end
    return r;
  endfunction

  function automatic date_t mk_date(input int y, input int m, input int d);
    date_t dt;
    dt.year  = YEAR_W'(y);
    dt.month = MONTH_W'(m);
    dt.day   = DAY_W'(d);
    return dt;
  endfunction

  // Mostly real dates, some hugging the year limits, some raw field noise
  function automatic date_t pick_date();
    date_t dt;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      dt = mk_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    end else if (roll < 30) begin
      dt = mk_date($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(9997, 9999),
                   $urandom_range(1, 12), $urandom_range(1, 31));
    end else begin
      dt = mk_date($urandom_range(0, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
    end
    return dt;
  endfunction

  function automatic logic signed [DV_W-1:0] pick_day_number();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return DV_W'($urandom_range(JD_FIRST, JD_LAST));
    if (roll < 80) return DV_W'($urandom_range(JD_FIRST - 400, JD_FIRST + 400));
    if (roll < 90) return DV_W'($urandom_range(JD_LAST - 400, JD_LAST + 400));
    return DV_W'($urandom);
  endfunction

  function automatic logic signed [DV_W-1:0] pick_offset();
    logic signed [DV_W-1:0] v;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50)      v = DV_W'($urandom_range(0, 400));
    else if (roll < 85) v = DV_W'($urandom_range(0, 3652059));
    else                v = DV_W'($urandom);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request side: random gap, then hold the request until s_tready is seen.
  // Handshakes are sampled at the falling edge, where every signal is stable;
  // the transfer itself happens at the next rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input op_t op, input date_t a, input date_t b,
                              input logic signed [DV_W-1:0] dv);
    int gap;
    gap = src_no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    // year_a month_a day_a year_b month_b day_b day_value, low bits first
    s_tdata  <= {2'b00, dv, b.day, b.month, b.year, a.day, a.month, a.year};
    do @(negedge clk); while (!s_tready);
    awaited_results.push_back(convert_request(op, a, b, dv));
    op_count[op]++;
    @(posedge clk);
  endtask

  // Result side: random stall before each result, then accept one
  initial begin : result_sink
    int stall;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      stall = sink_no_stall ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(negedge clk) begin : result_check
    conv_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding, tdata=%h", m_tdata));
      end else begin
        want = awaited_results.pop_front();
        if (want.out_of_range) range_flag_count++;
        if (m_tdata[22:0] !== want.day_result)
          note_mismatch($sformatf("day_result %0d, expected %0d", m_tdata[22:0], want.day_result));
        if (m_tdata[36:23] !== want.year)
          note_mismatch($sformatf("year_out %0d, expected %0d", m_tdata[36:23], want.year));
        if (m_tdata[40:37] !== want.month)
          note_mismatch($sformatf("month_out %0d, expected %0d", m_tdata[40:37], want.month));
        if (m_tdata[45:41] !== want.day)
          note_mismatch($sformatf("day_out %0d, expected %0d", m_tdata[45:41], want.day));
        if (m_tdata[47:46] !== 2'b00)
          note_mismatch($sformatf("tdata padding %b, expected 00", m_tdata[47:46]));
        if (m_tuser !== want.out_of_range)
          note_mismatch($sformatf("out_of_range %b, expected %b", m_tuser, want.out_of_range));
      end
    end
  end

  // Hang detector: too long with no transfer on either side ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("no handshake for %0d cycles, %0d results outstanding",
             quiet, awaited_results.size());
    $display("gregorian_julian_day_converter_core_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  task automatic test_date_to_day();
    date_t none;
    none = '0;
    send_request(OP_DATE_TO_DAY, mk_date(0, 1, 1), none, '0);
    send_request(OP_DATE_TO_DAY, mk_date(9999, 12, 31), none, '0);
    send_request(OP_DATE_TO_DAY, mk_date(2000, 2, 29), none, '0);      // leap century
    send_request(OP_DATE_TO_DAY, mk_date(1900, 3, 1), none, '0);       // non-leap century
    send_request(OP_DATE_TO_DAY, mk_date(2023, 0, 15), none, '0);      // month zero
    send_request(OP_DATE_TO_DAY, mk_date(16383, 15, 31), none, '0);    // all-ones fields
    send_request(OP_DATE_TO_DAY, mk_date(2024, 1, 0), none, '0);       // day zero
  endtask

  task automatic test_day_to_date();
    date_t none;
    none = '0;
    send_request(OP_DAY_TO_DATE, none, none, DV_W'(JD_FIRST));
    send_request(OP_DAY_TO_DATE, none, none, DV_W'(JD_FIRST - 1));     // year -1
    send_request(OP_DAY_TO_DATE, none, none, DV_W'(JD_LAST));
    send_request(OP_DAY_TO_DATE, none, none, DV_W'(JD_LAST + 1));      // year 10000
    send_request(OP_DAY_TO_DATE, none, none, 24'sh800000);             // most negative
    send_request(OP_DAY_TO_DATE, none, none, 24'sh7FFFFF);             // most positive
  endtask

  task automatic test_add_days();
    date_t none;
    none = '0;
    send_request(OP_ADD_DAYS, mk_date(9999, 12, 31), none, DV_W'(1));  // past the top
    send_request(OP_ADD_DAYS, mk_date(0, 1, 1), none, DV_W'(-1));      // below the bottom
    send_request(OP_ADD_DAYS, mk_date(2000, 2, 28), none, DV_W'(1));   // into Feb 29
    send_request(OP_ADD_DAYS, mk_date(2100, 3, 1), none, DV_W'(-1));   // back over short Feb
    send_request(OP_ADD_DAYS, mk_date(2024, 6, 15), none, 24'sh7FFFFF);
    send_request(OP_ADD_DAYS, mk_date(2024, 6, 15), none, 24'sh800000);
  endtask

  task automatic test_distance();
    send_request(OP_DISTANCE, mk_date(2024, 7, 4), mk_date(2024, 7, 4), '0);
    send_request(OP_DISTANCE, mk_date(0, 1, 1), mk_date(9999, 12, 31), '0);
    send_request(OP_DISTANCE, mk_date(9999, 12, 31), mk_date(0, 1, 1), '0);
    send_request(OP_DISTANCE, mk_date(16383, 15, 31), mk_date(0, 0, 0), '0);
  endtask

  // Random mix; every 50 requests each side picks busy-with-gaps or back-to-back
  task automatic test_random_mix();
    op_t op;
    logic signed [DV_W-1:0] dv;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) begin
        src_no_gap    = ($urandom_range(0, 3) == 0);
        sink_no_stall = ($urandom_range(0, 3) == 0);
      end
      op = op_t'($urandom_range(0, 3));
      case (op)
        OP_DAY_TO_DATE: dv = pick_day_number();
        OP_ADD_DAYS:    dv = pick_offset();
        default:        dv = DV_W'($urandom);   // ignored by these operations
      endcase
      send_request(op, pick_date(), pick_date(), dv);
    end
    src_no_gap    = 1'b0;
    sink_no_stall = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = OP_DATE_TO_DAY;
    m_tready         = 1'b0;
    mismatch_count   = 0;
    range_flag_count = 0;
    src_no_gap       = 1'b0;
    sink_no_stall    = 1'b0;
    op_count         = '{default: 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_date_to_day();
    test_day_to_date();
    test_add_days();
    test_distance();
    test_random_mix();

    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d date-to-day, %0d day-to-date, %0d add-days, %0d distance",
             op_count[OP_DATE_TO_DAY], op_count[OP_DAY_TO_DATE],
             op_count[OP_ADD_DAYS], op_count[OP_DISTANCE]);
    $display("results with year out of range: %0d, mismatches: %0d",
             range_flag_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("gregorian_julian_day_converter_core_tb passed");
    end else begin
      $display("gregorian_julian_day_converter_core_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gjd_pkg.sv
hdl/gjd_date2day.sv
hdl/gjd_day2date.sv
hdl/gregorian_julian_day_converter_core.sv
tb/gregorian_julian_day_converter_core_tb.sv
